### hdl/vmem_block_allocator_top_macros.svh
// Assertion macros for the allocator.
`ifndef VMEM_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define VMEM_BLOCK_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTH
`define VBA_ASSERT_IMPLY(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("allocator check failed");
`define VBA_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("allocator check failed");
`else
`define VBA_ASSERT_IMPLY(lbl, a, b)
`define VBA_ASSERT_NEXT(lbl, a, b)
`endif

`endif

### hdl/vba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vba_pkg;
  localparam int unsigned Entries = 64;
  localparam logic [10:0] PoolSize = 11'd1920;
  localparam logic [7:0] EndLink = 8'hFF;

  localparam logic [1:0] K_INV  = 2'd0;
  localparam logic [1:0] K_FREE = 2'd1;
  localparam logic [1:0] K_USED = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_ROOM   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [1:0] A_BEST = 2'd0;
  localparam logic [1:0] A_FIX  = 2'd1;
  localparam logic [1:0] A_FREE = 2'd2;
  localparam logic [1:0] A_NOP  = 2'd3;

  typedef struct packed {
    logic [10:0] size;
    logic [7:0]  link;
    logic [1:0]  kind;
  } entry_t;

  localparam entry_t EntryHead = '{size: PoolSize, link: EndLink, kind: K_FREE};
  localparam entry_t EntryNone = '{size: 11'd0, link: 8'd0, kind: K_INV};
endpackage
`default_nettype wire

### hdl/vba_table.sv
`timescale 1ns / 1ps
`default_nettype none
module vba_table
  import vba_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [5:0] rd_addr,
  output entry_t          rd_data,
  input  wire logic       wr_en,
  input  wire logic [5:0] wr_addr,
  input  wire entry_t     wr_data
);
  entry_t             mem [Entries];
  logic [Entries-1:0] vbit;
  entry_t             mem_q;
  logic               v_q;
  logic               a0_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbit <= '0;
      v_q  <= 1'b0;
      a0_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vbit[wr_addr] <= 1'b1;
      end
      v_q  <= vbit[rd_addr];
      a0_q <= (rd_addr == 6'd0);
    end
  end

  // untouched entries read as their reset contents
  assign rd_data = v_q ? mem_q : (a0_q ? EntryHead : EntryNone);
endmodule
`default_nettype wire

### hdl/vmem_block_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: action 3 or a zero-size allocate goes straight to the statistics scan; otherwise
// the chain is walked entry by entry (up to 64), then the block decides, splits or merges and
// writes back, then scans the table for statistics and registers the outputs.
// A new request is accepted only while busy is low, once the previous one has finished.
// Reset: table returns at once to one free block holding the whole pool.
// The done strobe lasts one cycle; the receiver cannot stall.
`include "vmem_block_allocator_top_macros.svh"
module vmem_block_allocator_top
  import vba_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [10:0] req_size,
  input  wire logic [10:0] alignment,
  input  wire logic [10:0] address,
  output logic             done,
  output logic [1:0]       status,
  output logic [10:0]      result_addr,
  output logic [10:0]      free_total,
  output logic [10:0]      used_total,
  output logic [10:0]      largest_free
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_EV    = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_SPLIT = 4'd4;
  localparam logic [3:0] S_FRD   = 4'd5;
  localparam logic [3:0] S_FEV   = 4'd6;
  localparam logic [3:0] S_WR    = 4'd7;
  localparam logic [3:0] S_STAT  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]  state;
  logic [1:0]  act;
  logic [10:0] req, al, addr_r, gaddr;
  logic [7:0]  p;
  logic [6:0]  steps, sc;
  logic [11:0] ca, cur_ca;
  logic        found, has_prev;
  logic [5:0]  cur_idx, prv_idx, m_idx;
  entry_t      cur, prv;
  logic [10:0] m_size;
  logic [7:0]  m_link;
  logic [1:0]  st;
  logic [6:0]  i0, i1, ni0, ni1;
  logic [10:0] fsum, usum, lg;
  logic [2:0]  wv;
  logic [5:0]  ws_idx [3];
  entry_t      ws_ent [3];

  entry_t      rd;
  logic [5:0]  rd_addr;
  logic        wr_en;
  logic [5:0]  wr_addr;
  entry_t      wr_data;
  logic [10:0] al_in;
  logic [10:0] al_m;
  logic [12:0] aa, ca_aa;
  logic [12:0] aoff13;
  logic [10:0] aoff;
  logic [5:0]  scan_idx;

  vba_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_comb begin
    al_in = 11'd1;
    for (int k = 0; k < 11; k++) begin
      if (alignment[k]) begin
        al_in = 11'd1 << k;
      end
    end
  end

  // round current chain address up to the alignment
  assign al_m = al - 11'd1;
  always_comb begin
    if (((ca & {1'b0, al_m}) != 12'd0)) begin
      aa = {1'b0, ca & ~{1'b0, al_m}} + {2'b00, al};
    end else begin
      aa = {1'b0, ca};
    end
    if (((cur_ca & {1'b0, al_m}) != 12'd0)) begin
      ca_aa = {1'b0, cur_ca & ~{1'b0, al_m}} + {2'b00, al};
    end else begin
      ca_aa = {1'b0, cur_ca};
    end
  end

  assign aoff13   = {2'b00, addr_r} - {1'b0, cur_ca};
  assign aoff     = aoff13[10:0];
  assign scan_idx = sc[5:0] - 6'd1;

  always_comb begin
    unique case (state)
      S_FRD:   rd_addr = m_link[5:0];
      S_STAT:  rd_addr = sc[5:0];
      default: rd_addr = p[5:0];
    endcase
  end

  always_comb begin
    wr_en   = (state == S_WR) && (wv != 3'b000);
    wr_addr = ws_idx[0];
    wr_data = ws_ent[0];
    if (!wv[0] && wv[1]) begin
      wr_addr = ws_idx[1];
      wr_data = ws_ent[1];
    end else if (!wv[0] && !wv[1]) begin
      wr_addr = ws_idx[2];
      wr_data = ws_ent[2];
    end
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      i0    <= 7'd1;
      i1    <= 7'd2;
      wv    <= 3'b000;
    end else begin
      done <= (state == S_FIN);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            act      <= action;
            req      <= req_size;
            al       <= al_in;
            addr_r   <= address;
            p        <= 8'd0;
            steps    <= 7'd0;
            ca       <= 12'd0;
            found    <= 1'b0;
            has_prev <= 1'b0;
            gaddr    <= 11'd0;
            sc       <= 7'd0;
            fsum     <= 11'd0;
            usum     <= 11'd0;
            lg       <= 11'd0;
            ni0      <= 7'd64;
            ni1      <= 7'd64;
            wv       <= 3'b000;
            if (action == A_NOP) begin
              st    <= ST_OK;
              state <= S_STAT;
            end else if (action != A_FREE && req_size == 11'd0) begin
              st    <= ST_NO_ROOM;
              state <= S_STAT;
            end else begin
              st    <= ST_OK;
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          if (p[7:6] != 2'b00 || steps[6]) begin
            state <= S_DEC;
          end else begin
            state <= S_EV;
          end
        end
        S_EV: begin
          if (rd.kind == K_INV) begin
            state <= S_DEC;
          end else if (act == A_FIX && ca <= {1'b0, addr_r} &&
                       ({1'b0, ca} + {2'b00, rd.size}) > {2'b00, addr_r}) begin
            found   <= 1'b1;
            cur     <= rd;
            cur_idx <= p[5:0];
            cur_ca  <= ca;
            state   <= S_DEC;
          end else if (act == A_FREE && ca == {1'b0, addr_r}) begin
            found   <= 1'b1;
            cur     <= rd;
            cur_idx <= p[5:0];
            cur_ca  <= ca;
            state   <= S_DEC;
          end else begin
            if (act == A_BEST && rd.kind == K_FREE &&
                ({2'b00, rd.size} + {1'b0, ca}) >= ({2'b00, req} + aa) &&
                (!found || cur.size > rd.size)) begin
              found   <= 1'b1;
              cur     <= rd;
              cur_idx <= p[5:0];
              cur_ca  <= ca;
            end
            if (act == A_FREE) begin
              prv      <= rd;
              prv_idx  <= p[5:0];
              has_prev <= 1'b1;
            end
            ca    <= ca + {1'b0, rd.size};
            p     <= rd.link;
            steps <= steps + 7'd1;
            state <= S_RD;
          end
        end
        S_DEC: begin
          if (act == A_FREE) begin
            if (!found) begin
              st    <= ST_NOT_FOUND;
              state <= S_STAT;
            end else begin
              gaddr <= addr_r;
              state <= S_FRD;
              if (has_prev && prv_idx != cur_idx && prv.kind == K_FREE) begin
                m_idx     <= prv_idx;
                m_size    <= prv.size + cur.size;
                m_link    <= cur.link;
                ws_idx[1] <= cur_idx;
                ws_ent[1] <= '{size: cur.size, link: cur.link, kind: K_INV};
                wv[1]     <= 1'b1;
              end else begin
                m_idx  <= cur_idx;
                m_size <= cur.size;
                m_link <= cur.link;
              end
            end
          end else if (!found) begin
            st    <= ST_NO_ROOM;
            state <= S_STAT;
          end else if (act == A_FIX) begin
            if (cur.kind != K_FREE ||
                ({1'b0, cur_ca} + {2'b00, cur.size}) < ({2'b00, addr_r} + {2'b00, req})) begin
              st    <= ST_NO_ROOM;
              state <= S_STAT;
            end else begin
              state <= S_SPLIT;
            end
          end else begin
            addr_r <= ca_aa[10:0];
            state  <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          if (cur_ca == {1'b0, addr_r} && cur.size == req) begin
            ws_idx[0] <= cur_idx;
            ws_ent[0] <= '{size: cur.size, link: cur.link, kind: K_USED};
            wv        <= 3'b001;
            gaddr     <= addr_r;
            state     <= S_WR;
          end else if (cur_ca == {1'b0, addr_r} ||
                       ({1'b0, cur_ca} + {2'b00, cur.size}) ==
                       ({2'b00, addr_r} + {2'b00, req})) begin
            if (i0[6]) begin
              st    <= ST_FULL;
              state <= S_STAT;
            end else begin
              ws_idx[0] <= i0[5:0];
              ws_idx[1] <= cur_idx;
              wv        <= 3'b011;
              gaddr     <= addr_r;
              state     <= S_WR;
              if (cur_ca == {1'b0, addr_r}) begin
                ws_ent[0] <= '{size: cur.size - req, link: cur.link, kind: K_FREE};
                ws_ent[1] <= '{size: req, link: {1'b0, i0}, kind: K_USED};
              end else begin
                ws_ent[0] <= '{size: req, link: cur.link, kind: K_USED};
                ws_ent[1] <= '{size: cur.size - req, link: {1'b0, i0}, kind: K_FREE};
              end
            end
          end else if (i1[6]) begin
            st    <= ST_FULL;
            state <= S_STAT;
          end else begin
            ws_idx[0] <= i1[5:0];
            ws_ent[0] <= '{size: cur.size - req - aoff, link: cur.link, kind: K_FREE};
            ws_idx[1] <= i0[5:0];
            ws_ent[1] <= '{size: req, link: {1'b0, i1}, kind: K_USED};
            ws_idx[2] <= cur_idx;
            ws_ent[2] <= '{size: aoff, link: {1'b0, i0}, kind: K_FREE};
            wv        <= 3'b111;
            gaddr     <= addr_r;
            state     <= S_WR;
          end
        end
        S_FRD: begin
          ws_idx[0] <= m_idx;
          ws_ent[0] <= '{size: m_size, link: m_link, kind: K_FREE};
          wv[0]     <= 1'b1;
          if (m_link[7:6] == 2'b00 && m_link[5:0] != m_idx) begin
            state <= S_FEV;
          end else begin
            state <= S_WR;
          end
        end
        S_FEV: begin
          if (rd.kind == K_FREE) begin
            ws_ent[0] <= '{size: m_size + rd.size, link: rd.link, kind: K_FREE};
            ws_idx[2] <= m_link[5:0];
            ws_ent[2] <= '{size: rd.size, link: rd.link, kind: K_INV};
            wv[2]     <= 1'b1;
          end
          state <= S_WR;
        end
        S_WR: begin
          if (wv[0]) begin
            wv[0] <= 1'b0;
          end else if (wv[1]) begin
            wv[1] <= 1'b0;
          end else if (wv[2]) begin
            wv[2] <= 1'b0;
          end else begin
            state <= S_STAT;
          end
        end
        S_STAT: begin
          if (sc != 7'd0) begin
            if (rd.kind == K_FREE) begin
              fsum <= fsum + rd.size;
              if (rd.size > lg) begin
                lg <= rd.size;
              end
            end else if (rd.kind == K_USED) begin
              usum <= usum + rd.size;
            end else if (rd.kind == K_INV) begin
              if (ni0[6]) begin
                ni0 <= {1'b0, scan_idx};
              end else if (ni1[6]) begin
                ni1 <= {1'b0, scan_idx};
              end
            end
          end
          if (sc[6]) begin
            state <= S_FIN;
          end
          sc <= sc + 7'd1;
        end
        S_FIN: begin
          status       <= st;
          result_addr  <= (st == ST_OK) ? gaddr : 11'd0;
          free_total   <= fsum;
          used_total   <= usum;
          largest_free <= lg;
          i0           <= ni0;
          i1           <= ni1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `VBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `VBA_ASSERT_IMPLY(a_err_addr, done && status != ST_OK, result_addr == 11'd0)
  `VBA_ASSERT_IMPLY(a_done_idle, done, !busy)
  `VBA_ASSERT_IMPLY(a_largest, done, largest_free <= free_total)
endmodule
`default_nettype wire
